// ===== rtl/core/swlc_pkg.sv =====
// Shared constants and control/status types for the size-weighted LRU cache.
package swlc_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_BITS  = 32;
  localparam int SIZE_BITS = 24;
  localparam int BUDGET_W  = 24;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int AGE_W = IDX_W;
  // compare width wide enough for both the size and the budget, plus a guard bit
  localparam int CMP_W = ((SIZE_BITS > BUDGET_W) ? SIZE_BITS : BUDGET_W) + 1;

  localparam logic [BUDGET_W-1:0] MAX_BYTES_RST = BUDGET_W'(1048576);

  // controller -> datapath
  typedef struct packed {
    logic             accept;
    logic             rd_key;
    logic [IDX_W-1:0] rd_addr;
    logic             hit_upd;
    logic             bypass;
    logic             zero_total;
    logic             evict_rd;
    logic             evict_upd;
    logic             insert;
    logic             load_out;
  } swlc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match;
    logic size_gt_max;
    logic need_evict;
    logic empty;
    logic full;
    logic out_free;
  } swlc_stat_t;

endpackage

// ===== rtl/core/swlc_ifs.sv =====
// Valid/ready channel interfaces for request and result beats.
interface swlc_req_if import swlc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KEY_BITS-1:0]  obj_key;
  logic [SIZE_BITS-1:0] obj_size;

  modport source(output valid, output obj_key, output obj_size, input ready);
  modport sink(input valid, input obj_key, input obj_size, output ready);
endinterface

interface swlc_rsp_if import swlc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                hit;
  logic                bypassed;
  logic [CNT_W-1:0]    evicted_count;
  logic [BUDGET_W-1:0] bytes_used;
  logic [CNT_W-1:0]    entries_held;

  modport source(output valid, output hit, output bypassed, output evicted_count,
                 output bytes_used, output entries_held, input ready);
  modport sink(input valid, input hit, input bypassed, input evicted_count,
               input bytes_used, input entries_held, output ready);
endinterface

// ===== rtl/core/swlc_ctrl.sv =====
// Sequencing state machine: key scan, hit update, bypass, eviction loop, insert, result.
module swlc_ctrl import swlc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  swlc_stat_t st,
  output swlc_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_HIT   = 7'b0000100,
    ST_CHK   = 7'b0001000,
    ST_EVICT = 7'b0010000,
    ST_INS   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // compare works on the registered result of the key read
        if (st.match) begin
          state_nxt = ST_HIT;
        end else if (cnt_r == CNT_W'(ENTRIES)) begin
          if (st.size_gt_max) begin
            cmd.bypass = 1'b1;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt = ST_CHK;
          end
        end else begin
          cmd.rd_key  = 1'b1;
          cmd.rd_addr = cnt_r[IDX_W-1:0];
          cnt_nxt     = cnt_r + 1'b1;
        end
      end
      ST_HIT: begin
        cmd.hit_upd = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_CHK: begin
        if (st.need_evict) begin
          if (st.empty) begin
            cmd.zero_total = 1'b1;
          end else begin
            cmd.evict_rd = 1'b1;
            state_nxt    = ST_EVICT;
          end
        end else if (st.full) begin
          cmd.evict_rd = 1'b1;
          state_nxt    = ST_EVICT;
        end else begin
          state_nxt = ST_INS;
        end
      end
      ST_EVICT: begin
        cmd.evict_upd = 1'b1;
        state_nxt     = ST_CHK;
      end
      ST_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> cnt_r <= CNT_W'(ENTRIES))
    else $error("scan counter past table depth");

  a_accept_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == ST_SCAN && cnt_r == '0)
    else $error("accepted beat did not start a scan");

  a_load_leaves_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> state_r == ST_IDLE)
    else $error("result load did not return to idle");

endmodule

// ===== rtl/core/swlc_dp.sv =====
// Datapath: key/size memories, recency ages, valid bits, byte total, result register.
module swlc_dp import swlc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [BUDGET_W-1:0]  cfg_wdata,
  input  logic [KEY_BITS-1:0]  in_key,
  input  logic [SIZE_BITS-1:0] in_size,
  input  logic                 out_ready,
  input  swlc_cmd_t            cmd,
  output swlc_stat_t           st,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic                 out_bypassed,
  output logic [CNT_W-1:0]     out_evicted_count,
  output logic [BUDGET_W-1:0]  out_bytes_used,
  output logic [CNT_W-1:0]     out_entries_held
);

  // storage
  logic [KEY_BITS-1:0]  key_mem  [ENTRIES];
  logic [SIZE_BITS-1:0] size_mem [ENTRIES];

  logic [AGE_W-1:0]    age_r   [ENTRIES];
  logic [AGE_W-1:0]    age_nxt [ENTRIES];
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [BUDGET_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]    cnt_valid_r, cnt_valid_nxt;
  logic [BUDGET_W-1:0] max_r;
  logic                out_valid_r;

  // request and per-request scratch
  logic [KEY_BITS-1:0]  req_key_r;
  logic [SIZE_BITS-1:0] req_size_r;
  logic [KEY_BITS-1:0]  key_q_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     found_idx_r;
  logic [IDX_W-1:0]     vic_idx_r;
  logic [SIZE_BITS-1:0] size_q_r;
  logic                 hit_f_r, byp_f_r;
  logic [CNT_W-1:0]     evc_r;

  logic                 match;
  logic [AGE_W-1:0]     hit_age;
  logic [AGE_W-1:0]     vic_age;
  logic [IDX_W-1:0]     vic_idx;
  logic                 vic_found;
  logic [IDX_W-1:0]     slot_idx;
  logic [BUDGET_W-1:0]  total_sub;

  assign match   = cmp_vld_r && valid_r[cmp_idx_r] && (key_q_r == req_key_r);
  assign hit_age = age_r[found_idx_r];
  assign vic_age = AGE_W'(cnt_valid_r - 1'b1);

  // oldest valid entry carries age count-1
  always_comb begin
    vic_idx   = '0;
    vic_found = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && age_r[i] == vic_age) begin
        vic_idx   = IDX_W'(i);
        vic_found = 1'b1;
      end
    end
  end

  // lowest free slot
  always_comb begin
    slot_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) slot_idx = IDX_W'(i);
    end
  end

  assign total_sub = (CMP_W'(total_r) >= CMP_W'(size_q_r)) ?
                     BUDGET_W'(CMP_W'(total_r) - CMP_W'(size_q_r)) : '0;

  always_comb begin
    st             = '0;
    st.match       = match;
    st.size_gt_max = CMP_W'(req_size_r) > CMP_W'(max_r);
    st.need_evict  = (total_r > max_r) ||
                     (CMP_W'(req_size_r) > (CMP_W'(max_r) - CMP_W'(total_r)));
    st.empty       = cnt_valid_r == '0;
    st.full        = cnt_valid_r == CNT_W'(ENTRIES);
    st.out_free    = !out_valid_r || out_ready;
  end

  // table state updates
  always_comb begin
    valid_nxt     = valid_r;
    age_nxt       = age_r;
    total_nxt     = total_r;
    cnt_valid_nxt = cnt_valid_r;
    if (cmd.hit_upd) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == found_idx_r) begin
          age_nxt[i] = '0;
        end else if (valid_r[i] && age_r[i] < hit_age) begin
          age_nxt[i] = age_r[i] + 1'b1;
        end
      end
    end
    if (cmd.bypass) begin
      valid_nxt     = '0;
      total_nxt     = '0;
      cnt_valid_nxt = '0;
    end
    if (cmd.zero_total) begin
      total_nxt = '0;
    end
    if (cmd.evict_upd) begin
      valid_nxt[vic_idx_r] = 1'b0;
      total_nxt            = total_sub;
      cnt_valid_nxt        = cnt_valid_r - 1'b1;
    end
    if (cmd.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i]) age_nxt[i] = age_r[i] + 1'b1;
      end
      age_nxt[slot_idx]   = '0;
      valid_nxt[slot_idx] = 1'b1;
      // fits: the eviction loop left room for the object
      total_nxt           = BUDGET_W'(CMP_W'(total_r) + CMP_W'(req_size_r));
      cnt_valid_nxt       = cnt_valid_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      total_r     <= '0;
      cnt_valid_r <= '0;
      max_r       <= MAX_BYTES_RST;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) age_r[i] <= '0;
    end else begin
      valid_r     <= valid_nxt;
      total_r     <= total_nxt;
      cnt_valid_r <= cnt_valid_nxt;
      age_r       <= age_nxt;
      cmp_vld_r   <= cmd.rd_key;
      if (cfg_we) max_r <= cfg_wdata;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      key_mem[slot_idx]  <= req_key_r;
      size_mem[slot_idx] <= req_size_r;
    end
    if (cmd.rd_key) key_q_r <= key_mem[cmd.rd_addr];
    if (cmd.evict_rd) size_q_r <= size_mem[vic_idx];
  end

  // request scratch and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_key_r  <= in_key;
      req_size_r <= in_size;
      hit_f_r    <= 1'b0;
      byp_f_r    <= 1'b0;
      evc_r      <= '0;
    end
    if (cmd.rd_key) cmp_idx_r <= cmd.rd_addr;
    if (match) found_idx_r <= cmp_idx_r;
    if (cmd.evict_rd) vic_idx_r <= vic_idx;
    if (cmd.hit_upd) hit_f_r <= 1'b1;
    if (cmd.bypass) begin
      byp_f_r <= 1'b1;
      evc_r   <= cnt_valid_r;
    end
    if (cmd.evict_upd) evc_r <= evc_r + 1'b1;
    if (cmd.load_out) begin
      out_hit           <= hit_f_r;
      out_bypassed      <= byp_f_r;
      out_evicted_count <= evc_r;
      out_bytes_used    <= total_r;
      out_entries_held  <= cnt_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(cnt_valid_r))
    else $error("entry count out of step with valid bits");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_valid_r <= CNT_W'(ENTRIES))
    else $error("entry count exceeds table depth");

  a_victim_exists: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evict_rd |-> vic_found)
    else $error("eviction with no oldest entry");

  a_bypass_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out && byp_f_r |=> out_bytes_used == '0 && out_entries_held == '0)
    else $error("bypass result reports held bytes or entries");

endmodule

// ===== rtl/core/size_weighted_lru_cache.sv =====
// Top level of the size-weighted LRU cache tracker.
// Usage:
//   in_ch  : request beats {obj_key, obj_size}, taken when valid && ready.
//   out_ch : one result beat per request {hit, bypassed, evicted_count,
//            bytes_used, entries_held}, taken when valid && ready.
//   cfg_we/cfg_wdata : writes the byte budget (max_bytes); write only while
//            no request is in flight.
// Sequence: one request at a time. The key scan walks the key memory one
//   entry a cycle and ends early on a hit. A hit then updates the ages, a
//   bypass clears the table. A miss checks budget and fill, evicts entries
//   one by one (one size-memory read, one update each), then inserts.
//   Each request ends by loading its result into the output register.
// Throughput: the next request is taken in the cycle after the result is
//   loaded into the output register, while that result may still wait.
// Reset (rst_n low at a clock edge): all entries invalid, ages and byte total
//   zero, budget 1048576. Key and size memories are not cleared; a key read
//   from an invalid entry never matches, and only valid sizes are read.
// Stall: a result held by a stalled receiver keeps its beat; the block
//   finishes the following request and then waits until the register frees.
module size_weighted_lru_cache import swlc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [BUDGET_W-1:0] cfg_wdata,
  swlc_req_if.sink            in_ch,
  swlc_rsp_if.source          out_ch
);

  swlc_cmd_t  cmd;
  swlc_stat_t st;

  // sequencer
  swlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // table, byte accounting and result register
  swlc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_key            (in_ch.obj_key),
    .in_size           (in_ch.obj_size),
    .out_ready         (out_ch.ready),
    .cmd               (cmd),
    .st                (st),
    .out_valid         (out_ch.valid),
    .out_hit           (out_ch.hit),
    .out_bypassed      (out_ch.bypassed),
    .out_evicted_count (out_ch.evicted_count),
    .out_bytes_used    (out_ch.bytes_used),
    .out_entries_held  (out_ch.entries_held)
  );

endmodule
